// ===== hw/rtl/frer_duplicate_eliminator_defines.svh =====
// Assertion macros shared by the duplicate eliminator RTL.
`ifndef FRER_DUPLICATE_ELIMINATOR_DEFINES_SVH
`define FRER_DUPLICATE_ELIMINATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FDE_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication checked outside reset.
`define FDE_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== hw/rtl/fde_pkg.sv =====
// Package with sizes, types and slot operations of the duplicate eliminator.
package fde_pkg;
   localparam int NUM_FLOWS = 16;
   localparam int MAX_INTERVALS = 8;
   localparam int FLOW_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   // Per-cycle command to every interval slot of the selected flow.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_EXT_HI,   // set high of slot i to seq
      OP_MERGE,    // slot i takes high of slot i+1, slots above shift down
      OP_EXT_LO,   // lower low of slot i+1 by one
      OP_INSERT,   // seq goes to slot i+1, slots above shift up
      OP_APPEND,   // seq goes to slot n
      OP_INIT      // slot 0 becomes {seq,seq}
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [CNT_W-1:0] idx;
      logic [15:0]      seq;
   } slot_cmd_type;
endpackage

// ===== hw/rtl/fde_cell.sv =====
// One interval slot of a flow row; it reads its neighbours for shifts.
module fde_cell (
   input  logic                 clock,
   input  logic                 write_en,
   input  fde_pkg::slot_cmd_type cmd,
   input  logic [fde_pkg::CNT_W-1:0] my_idx,
   input  logic [15:0]          below_lo,
   input  logic [15:0]          below_hi,
   input  logic [15:0]          above_lo,
   input  logic [15:0]          above_hi,
   output logic [15:0]          lo,
   output logic [15:0]          hi
);
   import fde_pkg::*;
   logic [15:0] lo_ff, hi_ff, lo_in, hi_in;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      unique case (cmd.op) inside
         OP_EXT_HI: if (my_idx == cmd.idx) hi_in = cmd.seq;
         OP_MERGE: begin
            if (my_idx == cmd.idx) hi_in = above_hi;
            else if (my_idx > cmd.idx) begin
               lo_in = above_lo;
               hi_in = above_hi;
            end
         end
         OP_EXT_LO: if (my_idx == cmd.idx + 1'b1) lo_in = lo_ff - 16'd1;
         OP_INSERT: begin
            if (my_idx == cmd.idx + 1'b1) begin
               lo_in = cmd.seq;
               hi_in = cmd.seq;
            end else if (my_idx > cmd.idx + 1'b1) begin
               lo_in = below_lo;
               hi_in = below_hi;
            end
         end
         OP_APPEND, OP_INIT: if (my_idx == cmd.idx) begin
            lo_in = cmd.seq;
            hi_in = cmd.seq;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;
endmodule

// ===== hw/rtl/fde_row.sv =====
// Interval list of one flow: a chain of slot cells plus key and count.
module fde_row (
   input  logic                      clock,
   input  logic                      write_en,
   input  fde_pkg::slot_cmd_type     cmd,
   input  logic [fde_pkg::CNT_W-1:0] cnt_in,
   input  logic [31:0]               key_in,
   input  logic                      key_we,
   output logic [31:0]               key,
   output logic [fde_pkg::CNT_W-1:0] cnt,
   output logic [16*fde_pkg::MAX_INTERVALS-1:0] lo_vec,
   output logic [16*fde_pkg::MAX_INTERVALS-1:0] hi_vec
);
   import fde_pkg::*;
   logic [31:0] key_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [15:0] lo_a [MAX_INTERVALS+1];
   logic [15:0] hi_a [MAX_INTERVALS+1];

   assign lo_a[MAX_INTERVALS] = '0;
   assign hi_a[MAX_INTERVALS] = '0;

   for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_slot
      fde_cell u_cell (
         .clock    (clock),
         .write_en (write_en),
         .cmd      (cmd),
         .my_idx   (CNT_W'(g)),
         .below_lo (lo_a[(g == 0) ? 0 : g-1]),
         .below_hi (hi_a[(g == 0) ? 0 : g-1]),
         .above_lo (lo_a[g+1]),
         .above_hi (hi_a[g+1]),
         .lo       (lo_a[g]),
         .hi       (hi_a[g])
      );
      assign lo_vec[16*g +: 16] = lo_a[g];
      assign hi_vec[16*g +: 16] = hi_a[g];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_ff <= key_in;
      if (write_en) cnt_ff <= cnt_in;
   end

   assign key = key_ff;
   assign cnt = cnt_ff;
endmodule

// ===== hw/rtl/frer_duplicate_eliminator.sv =====
// Top level of the FRER duplicate eliminator with per-flow interval lists.
// Requests arrive on the req_ stream: tdata holds flow_id in bits 31:0 and
// seq_num in bits 47:32. Every request gives exactly one response on the rsp_
// stream, whose tdata holds discard, new_flow and overflow from bit 0 up.
// A request first searches the flow table, one slot per cycle, taking the
// lowest used slot whose key matches and remembering the first free slot.
// A known flow then walks its interval list one interval per cycle until the
// sequence number is placed, and the list update is written in a single write to
// the row of interval cells, which shift their neighbours on merge or insert.
// The response is registered after the flow search, the walk steps (none for
// a new or rejected flow) and the result state have passed; requests are
// handled one at a time, and the next request is taken only once the result
// state has handed its result to the output register.
// The response sits in an output register; once a result has moved there the
// next request is accepted even while the receiver stalls, and its result
// waits until that register has been emptied.
// Reset clears the table's used bits, the state, output valid and search flags;
// other registers are written before they are read and need no clearing.
`include "frer_duplicate_eliminator_defines.svh"
module frer_duplicate_eliminator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // flow_id [31:0], seq_num [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // discard [0], new_flow [1], overflow [2]
);
   import fde_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_WALK, S_RESULT} state_type;

   state_type state_ff;
   logic [31:0] fid_ff;
   logic [15:0] seq_ff;
   logic [FLOW_W:0] scan_ff;
   logic found_ff, free_ff;
   logic [FLOW_W-1:0] hit_ff, freeslot_ff;
   logic [CNT_W-1:0] i_ff;
   logic [NUM_FLOWS-1:0] used_ff;
   logic [2:0] res_ff;
   logic [2:0] rsp_res_ff;
   logic rsp_valid_ff;

   logic [31:0] key_r [NUM_FLOWS];
   logic [CNT_W-1:0] cnt_r [NUM_FLOWS];
   logic [16*MAX_INTERVALS-1:0] lo_r [NUM_FLOWS];
   logic [16*MAX_INTERVALS-1:0] hi_r [NUM_FLOWS];

   slot_cmd_type cmd;
   logic [CNT_W-1:0] cnt_new;
   logic [NUM_FLOWS-1:0] row_we, key_we;
   logic [FLOW_W-1:0] scan_idx;
   logic [FLOW_W-1:0] row_sel;
   logic [CNT_W-1:0] n_sel;
   logic [15:0] lo_i, hi_i, lo_n;
   logic [16:0] hi_p1, hi_p2, s_p1, s_p2;
   logic has_next;
   logic walk_done;
   logic [2:0] walk_res;

   assign scan_idx = scan_ff[FLOW_W-1:0];

   for (genvar f = 0; f < NUM_FLOWS; f++) begin : g_row
      fde_row u_row (
         .clock   (clock),
         .write_en(row_we[f]),
         .cmd     (cmd),
         .cnt_in  (cnt_new),
         .key_in  (fid_ff),
         .key_we  (key_we[f]),
         .key     (key_r[f]),
         .cnt     (cnt_r[f]),
         .lo_vec  (lo_r[f]),
         .hi_vec  (hi_r[f])
      );
   end

   // Walk datapath: current interval and its successor of the hit flow.
   assign row_sel = hit_ff;
   always_comb begin
      n_sel = (cnt_r[row_sel] > CNT_W'(MAX_INTERVALS)) ?
              CNT_W'(MAX_INTERVALS) : cnt_r[row_sel];
      lo_i = lo_r[row_sel][16*i_ff +: 16];
      hi_i = hi_r[row_sel][16*i_ff +: 16];
      has_next = ({1'b0, i_ff} + 1'b1) < {1'b0, n_sel};
      lo_n = has_next ? lo_r[row_sel][16*(i_ff + 1'b1) +: 16] : 16'd0;
      hi_p1 = {1'b0, hi_i} + 17'd1;
      hi_p2 = {1'b0, hi_i} + 17'd2;
      s_p1 = {1'b0, seq_ff} + 17'd1;
      s_p2 = {1'b0, seq_ff} + 17'd2;
   end

   // One walk step: decides the walk end and the list change; OP_INIT in search.
   always_comb begin
      cmd.op = OP_HOLD;
      cmd.idx = i_ff;
      cmd.seq = seq_ff;
      cnt_new = n_sel;
      walk_done = 1'b1;
      walk_res = 3'b001;
      if (i_ff >= n_sel) begin
         walk_res = 3'b001;
      end else if (seq_ff >= lo_i && seq_ff <= hi_i) begin
         walk_res = 3'b001;
      end else if ({1'b0, seq_ff} == hi_p1) begin
         walk_res = 3'b000;
         if (has_next && s_p1 == {1'b0, lo_n}) begin
            cmd.op = OP_MERGE;
            cnt_new = n_sel - 1'b1;
         end else begin
            cmd.op = OP_EXT_HI;
         end
      end else if ({1'b0, seq_ff} >= hi_p2) begin
         walk_res = 3'b000;
         if (has_next) begin
            if (s_p1 == {1'b0, lo_n}) begin
               cmd.op = OP_EXT_LO;
            end else if (s_p2 <= {1'b0, lo_n}) begin
               if (n_sel >= CNT_W'(MAX_INTERVALS)) walk_res = 3'b100;
               else begin
                  cmd.op = OP_INSERT;
                  cnt_new = n_sel + 1'b1;
               end
            end else begin
               walk_done = 1'b0;
            end
         end else if (n_sel >= CNT_W'(MAX_INTERVALS)) begin
            walk_res = 3'b100;
         end else begin
            cmd.op = OP_APPEND;
            cmd.idx = n_sel;
            cnt_new = n_sel + 1'b1;
         end
      end
      if (state_ff == S_SEARCH) begin
         cmd.op = OP_INIT;
         cmd.idx = '0;
         cnt_new = CNT_W'(1);
      end
   end

   // Row writes: the hit row on a finishing walk step, the free row on a new flow.
   logic search_end, new_flow_now;
   assign search_end = (state_ff == S_SEARCH) && (scan_ff == (FLOW_W+1)'(NUM_FLOWS));
   assign new_flow_now = search_end && !found_ff && free_ff;
   always_comb begin
      row_we = '0;
      key_we = '0;
      if (new_flow_now) begin
         row_we[freeslot_ff] = 1'b1;
         key_we[freeslot_ff] = 1'b1;
      end else if (state_ff == S_WALK && walk_done) begin
         row_we[hit_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff <= '0;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         // The output register is loaded when it is empty or being emptied.
         if (state_ff == S_RESULT && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  fid_ff <= req_tdata[31:0];
                  seq_ff <= req_tdata[47:32];
                  scan_ff <= '0;
                  found_ff <= 1'b0;
                  free_ff <= 1'b0;
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (search_end) begin
                  if (found_ff) begin
                     i_ff <= '0;
                     state_ff <= S_WALK;
                  end else begin
                     if (free_ff) used_ff[freeslot_ff] <= 1'b1;
                     res_ff <= free_ff ? 3'b010 : 3'b100;
                     state_ff <= S_RESULT;
                  end
               end else begin
                  scan_ff <= scan_ff + 1'b1;
                  if (used_ff[scan_idx]) begin
                     if (!found_ff && key_r[scan_idx] == fid_ff) begin
                        found_ff <= 1'b1;
                        hit_ff <= scan_idx;
                     end
                  end else if (!free_ff) begin
                     free_ff <= 1'b1;
                     freeslot_ff <= scan_idx;
                  end
               end
            end
            S_WALK: begin
               if (walk_done) begin
                  res_ff <= walk_res;
                  state_ff <= S_RESULT;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_res_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_res_ff};

   `FDE_ASSERT_IMP(a_rsp_onehot_flags, clock, reset, rsp_tvalid,
      $countones(rsp_tdata[2:0]) <= 1, "response flags not exclusive")
   `FDE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `FDE_ASSERT_IMP(a_walk_in_range, clock, reset, state_ff == S_WALK,
      i_ff < CNT_W'(MAX_INTERVALS), "walk index beyond list")
   `FDE_ASSERT_NXT(a_new_flow_used, clock, reset, new_flow_now,
      used_ff[$past(freeslot_ff)], "new flow slot not marked used")
endmodule
